@@ hdl/phsl_pkg.sv @@
// Shared types and constants for the packed HSL to RGB converter.
package phsl_pkg;

  // Packed input layout
  localparam int unsigned HUE_LSB = 10;
  localparam int unsigned SAT_LSB = 7;
  localparam int unsigned HUE_W   = 6;
  localparam int unsigned SAT_W   = 3;
  localparam int unsigned LIT_W   = 7;

  // Channel numerators are kept over 28448 = 32 * 7 * 127
  localparam int unsigned NUM_W    = 15;
  localparam int unsigned HALF_DEN = 28448;
  // 2 * 28448 = 64 * 889: shift by 6, then divide by 889
  localparam int unsigned DEN_SHIFT = 6;
  localparam int unsigned DEN_ODD   = 889;

  localparam logic [LIT_W-1:0] LIT_MAX = 7'd127;
  localparam logic [LIT_W-1:0] HUE_HALF = 7'd64;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  // Per-stage load enables of the five-stage pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } phsl_adv_t;

endpackage

@@ hdl/phsl_chroma.sv @@
// Stages 1-2: unpack HSL, form chroma, secondary and offset, route by hue sector.
module phsl_chroma import phsl_pkg::*; (
  input  logic               clk_i,
  input  phsl_adv_t          adv_i,
  input  logic [15:0]        packed_hsl_i,
  output logic [NUM_W-1:0]   num_r_o,
  output logic [NUM_W-1:0]   num_g_o,
  output logic [NUM_W-1:0]   num_b_o
);

  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] sat;
  logic [LIT_W-1:0] lit;
  logic [LIT_W:0]   twol;
  logic [LIT_W:0]   lit_dev;
  logic [8:0]       six;
  logic [6:0]       rem;
  logic [6:0]       rdist;
  logic [6:0]       frac;

  logic [9:0]       cn_d, cn_q;
  logic [5:0]       f2_d, f2_q;
  sector_e          sec_d, sec_q;
  logic [LIT_W-1:0] lit_q;

  logic [NUM_W-1:0] lo, mid, hi;
  logic [NUM_W-1:0] r_d, g_d, b_d;
  logic [NUM_W-1:0] r_q, g_q, b_q;

  always_comb begin
    hue  = packed_hsl_i[HUE_LSB +: HUE_W];
    sat  = packed_hsl_i[SAT_LSB +: SAT_W];
    lit  = packed_hsl_i[LIT_W-1:0];
    twol = {lit, 1'b0};
    lit_dev = (twol >= {1'b0, LIT_MAX}) ? (twol - {1'b0, LIT_MAX})
                                        : ({1'b0, LIT_MAX} - twol);
    cn_d = 10'(LIT_MAX - lit_dev[LIT_W-1:0]) * 10'(sat);
    six  = 9'(hue) * 9'd6;
    rem  = six[6:0];
    rdist = (rem >= HUE_HALF) ? (rem - HUE_HALF) : (HUE_HALF - rem);
    frac = HUE_HALF - rdist;
    // 6h is even, so the hue ramp is always even
    f2_d = frac[6:1];
    sec_d = sector_e'(six[8:6]);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      cn_q  <= cn_d;
      f2_q  <= f2_d;
      sec_q <= sec_d;
      lit_q <= lit;
    end
  end

  always_comb begin
    lo  = (NUM_W'(lit_q) * NUM_W'(224)) - (NUM_W'(cn_q) << 4);
    mid = (NUM_W'(cn_q) * NUM_W'(f2_q)) + lo;
    hi  = (NUM_W'(cn_q) << 5) + lo;
    unique case (sec_q)
      SEC_RED_YEL: begin r_d = hi;  g_d = mid; b_d = lo;  end
      SEC_YEL_GRN: begin r_d = mid; g_d = hi;  b_d = lo;  end
      SEC_GRN_CYN: begin r_d = lo;  g_d = hi;  b_d = mid; end
      SEC_CYN_BLU: begin r_d = lo;  g_d = mid; b_d = hi;  end
      SEC_BLU_MAG: begin r_d = mid; g_d = lo;  b_d = hi;  end
      default:     begin r_d = hi;  g_d = lo;  b_d = mid; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      r_q <= r_d;
      g_q <= g_d;
      b_q <= b_d;
    end
  end

  assign num_r_o = r_q;
  assign num_g_o = g_q;
  assign num_b_o = b_q;

endmodule

@@ hdl/phsl_scale.sv @@
// Stages 3-5: scale one channel numerator to CHANNEL_BITS with round half up.
module phsl_scale import phsl_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                    clk_i,
  input  phsl_adv_t               adv_i,
  input  logic [NUM_W-1:0]        num_i,
  output logic [CHANNEL_BITS-1:0] chan_o
);

  localparam int unsigned SW  = CHANNEL_BITS + NUM_W + 2;
  localparam int unsigned NW  = SW - DEN_SHIFT;
  localparam int unsigned KSH = NW + 10;
  localparam int unsigned MW  = NW + 1;
  localparam int unsigned PW  = NW + MW;
  localparam int unsigned QW  = NW - 9;
  localparam logic [CHANNEL_BITS-1:0] SCALE = '1;
  localparam logic [CHANNEL_BITS:0]   TWO_SCALE = {SCALE, 1'b0};
  localparam logic [MW-1:0] RECIP = MW'((64'd1 << KSH) / 64'(DEN_ODD));

  logic [SW-1:0] sum;
  logic [NW-1:0] n3_q, n4_q;
  logic [PW-1:0] prod;
  logic [QW-1:0] qe_q;
  logic [NW-1:0] qm;
  logic [NW-1:0] rem;
  logic [QW-1:0] qf;
  logic [CHANNEL_BITS-1:0] chan_q;

  assign sum = (SW'(TWO_SCALE) * SW'(num_i)) + SW'(HALF_DEN);

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      n3_q <= NW'(sum >> DEN_SHIFT);
    end
  end

  // Reciprocal estimate is exact or one low
  assign prod = PW'(n3_q) * PW'(RECIP);

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      n4_q <= n3_q;
      qe_q <= QW'(prod >> KSH);
    end
  end

  always_comb begin
    qm  = NW'(qe_q) * NW'(DEN_ODD);
    rem = n4_q - qm;
    qf  = (rem >= NW'(DEN_ODD)) ? (qe_q + QW'(1)) : qe_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s5) begin
      chan_q <= CHANNEL_BITS'(qf);
    end
  end

  assign chan_o = chan_q;

endmodule

@@ hdl/packed_hsl_to_rgb.sv @@
// Packed HSL to RGB converter: five-stage pipeline, one color per cycle
// while ready_i is high. A color passes stages s1 to s5 in order, and
// valid_o is the valid bit of stage s5 (five register stages).
// Each stage loads when empty or when the next stage moves, so bubbles
// close up under output backpressure.
// Reset clears the stage valid bits only; data registers are not reset.
module packed_hsl_to_rgb import phsl_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [15:0]             packed_hsl_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [CHANNEL_BITS-1:0] red_o,
  output logic [CHANNEL_BITS-1:0] green_o,
  output logic [CHANNEL_BITS-1:0] blue_o
);

  logic [4:0] vld_q, vld_d;
  phsl_adv_t  adv;
  logic [NUM_W-1:0] num_r, num_g, num_b;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    adv.s5 = ~vld_q[4] | ready_i;
    adv.s4 = ~vld_q[3] | adv.s5;
    adv.s3 = ~vld_q[2] | adv.s4;
    adv.s2 = ~vld_q[1] | adv.s3;
    adv.s1 = ~vld_q[0] | adv.s2;
    vld_d[0] = adv.s1 ? valid_i  : vld_q[0];
    vld_d[1] = adv.s2 ? vld_q[0] : vld_q[1];
    vld_d[2] = adv.s3 ? vld_q[1] : vld_q[2];
    vld_d[3] = adv.s4 ? vld_q[2] : vld_q[3];
    vld_d[4] = adv.s5 ? vld_q[3] : vld_q[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ready_o = adv.s1;
  assign valid_o = vld_q[4];

  phsl_chroma u_chroma (
    .clk_i        (clk_i),
    .adv_i        (adv),
    .packed_hsl_i (packed_hsl_i),
    .num_r_o      (num_r),
    .num_g_o      (num_g),
    .num_b_o      (num_b)
  );

  phsl_scale #(.CHANNEL_BITS(CHANNEL_BITS)) u_scale_r (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .num_i  (num_r),
    .chan_o (red_o)
  );

  phsl_scale #(.CHANNEL_BITS(CHANNEL_BITS)) u_scale_g (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .num_i  (num_g),
    .chan_o (green_o)
  );

  phsl_scale #(.CHANNEL_BITS(CHANNEL_BITS)) u_scale_b (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .num_i  (num_b),
    .chan_o (blue_o)
  );

endmodule
